@@ rtl/core/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// slt_pkg
// Types and constants shared by the sleep and tilt-lock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_DEEP_TIMEOUT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LIGHT_TIMEOUT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SAVING_IDLE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHORT_PRESS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WAKE_GUARD    = 3'd4;

  // Register values after reset.
  localparam logic [31:0] DEEP_TIMEOUT_RST  = 32'd0;
  localparam logic [31:0] LIGHT_TIMEOUT_RST = 32'd0;
  localparam logic [31:0] SAVING_IDLE_RST   = 32'd1000;
  localparam logic [15:0] SHORT_PRESS_RST   = 16'd800;
  localparam logic [15:0] WAKE_GUARD_RST    = 16'd2000;

  // Idle loop delay classes.
  localparam logic [1:0] DELAY_1MS  = 2'd0;
  localparam logic [1:0] DELAY_10MS = 2'd1;
  localparam logic [1:0] DELAY_50MS = 2'd2;

  typedef struct packed {
    logic [31:0] deep_timeout_ms;
    logic [31:0] light_timeout_ms;
    logic [31:0] saving_idle_ms;
    logic [15:0] short_press_ms;
    logic [15:0] wake_guard_ms;
  } cfg_t;

  typedef struct packed {
    logic        wake_hold;
    logic [31:0] now_ms;
    logic        power_pressed;
    logic        any_pressed;
    logic        any_released;
    logic        power_released;
    logic [15:0] power_held_ms;
    logic        tilt_activity;
    logic        sleep_blocked;
    logic        on_reader;
  } poll_t;

  typedef struct packed {
    logic       enter_deep_sleep;
    logic       tilt_locked;
    logic       tilt_toggled;
    logic       tilt_sensor_off;
    logic       wake_released;
    logic       wake_pending;
    logic       power_saving;
    logic [1:0] idle_delay;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/slt_ifs.sv @@
// ----------------------------------------------------------------------------
// slt_ifs
// Valid/ready channels carrying polls in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface slt_poll_if;
  logic        valid;
  logic        ready;
  logic        wake_hold;
  logic [31:0] now_ms;
  logic        power_pressed;
  logic        any_pressed;
  logic        any_released;
  logic        power_released;
  logic [15:0] power_held_ms;
  logic        tilt_activity;
  logic        sleep_blocked;
  logic        on_reader;

  modport source (
    output valid, wake_hold, now_ms, power_pressed, any_pressed, any_released,
           power_released, power_held_ms, tilt_activity, sleep_blocked, on_reader,
    input  ready
  );
  modport sink (
    input  valid, wake_hold, now_ms, power_pressed, any_pressed, any_released,
           power_released, power_held_ms, tilt_activity, sleep_blocked, on_reader,
    output ready
  );
endinterface

interface slt_res_if;
  logic       valid;
  logic       ready;
  logic       enter_deep_sleep;
  logic       tilt_locked;
  logic       tilt_toggled;
  logic       tilt_sensor_off;
  logic       wake_released;
  logic       wake_pending;
  logic       power_saving;
  logic [1:0] idle_delay;

  modport source (
    output valid, enter_deep_sleep, tilt_locked, tilt_toggled, tilt_sensor_off,
           wake_released, wake_pending, power_saving, idle_delay,
    input  ready
  );
  modport sink (
    input  valid, enter_deep_sleep, tilt_locked, tilt_toggled, tilt_sensor_off,
           wake_released, wake_pending, power_saving, idle_delay,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/slt_cfg.sv @@
// ----------------------------------------------------------------------------
// slt_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [slt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [slt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output slt_pkg::cfg_t                      cfg_o
);
  import slt_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deep_timeout_ms  <= DEEP_TIMEOUT_RST;
      cfg_q.light_timeout_ms <= LIGHT_TIMEOUT_RST;
      cfg_q.saving_idle_ms   <= SAVING_IDLE_RST;
      cfg_q.short_press_ms   <= SHORT_PRESS_RST;
      cfg_q.wake_guard_ms    <= WAKE_GUARD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEEP_TIMEOUT:  cfg_q.deep_timeout_ms  <= cfg_wdata_i;
        REG_LIGHT_TIMEOUT: cfg_q.light_timeout_ms <= cfg_wdata_i;
        REG_SAVING_IDLE:   cfg_q.saving_idle_ms   <= cfg_wdata_i;
        REG_SHORT_PRESS:   cfg_q.short_press_ms   <= cfg_wdata_i[15:0];
        REG_WAKE_GUARD:    cfg_q.wake_guard_ms    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/slt_core.sv @@
// ----------------------------------------------------------------------------
// slt_core
// Controller state and the combinational update for one poll.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire slt_pkg::poll_t poll_i,
  input  wire slt_pkg::cfg_t  cfg_i,
  output slt_pkg::res_t       res_o
);
  import slt_pkg::*;

  logic [31:0] last_act_q, last_act_d;
  logic [31:0] allow_q, allow_d;
  logic        pending_q, pending_d;
  logic        rel_wake_q, rel_wake_d;
  logic        lock_q, lock_d;
  logic        saving_q, saving_d;

  logic [31:0] la_wake, la_act, idle;
  logic        pend_wake, activity, edge_seen, short_rel, lock_tog, saving_act;
  logic        hold_deep, deep_hit, light_hit, deep, toggled, sensor_off;
  logic [1:0]  delay;

  always_comb begin
    // Wake hold and activity note.
    la_wake   = poll_i.wake_hold ? poll_i.now_ms : last_act_q;
    allow_d   = poll_i.wake_hold ? (poll_i.now_ms + {16'd0, cfg_i.wake_guard_ms}) : allow_q;
    pend_wake = poll_i.wake_hold | pending_q;
    edge_seen = poll_i.any_pressed | poll_i.any_released;
    activity  = edge_seen | poll_i.tilt_activity;
    la_act    = activity ? poll_i.now_ms : la_wake;
    saving_act = activity ? 1'b0 : saving_q;
    rel_wake_d = rel_wake_q | ~poll_i.power_pressed;

    // A release of the power button consumes the pending wake hold.
    pending_d = pend_wake & poll_i.power_pressed;

    short_rel = poll_i.power_released && (poll_i.power_held_ms <= cfg_i.short_press_ms);
    toggled   = ~pending_d & short_rel;
    lock_tog  = lock_q;
    if (!pending_d) begin
      if (short_rel) begin
        lock_tog = ~lock_q;
      end else if (lock_q && edge_seen) begin
        lock_tog = 1'b0;
      end
    end

    // Sleep check; unless sleep is blocked, a zero activity time is taken as the present poll.
    last_act_d = la_act;
    if (!poll_i.sleep_blocked && (la_act == 32'd0)) begin
      last_act_d = poll_i.now_ms;
    end
    idle      = poll_i.now_ms - last_act_d;
    hold_deep = rel_wake_d && (poll_i.now_ms >= allow_d) && poll_i.power_pressed &&
                (poll_i.power_held_ms > cfg_i.short_press_ms);
    deep_hit  = (cfg_i.deep_timeout_ms != 32'd0) && (idle >= cfg_i.deep_timeout_ms);
    light_hit = (cfg_i.light_timeout_ms != 32'd0) && !lock_tog &&
                (idle >= cfg_i.light_timeout_ms);
    deep      = !poll_i.sleep_blocked && (hold_deep || deep_hit);
    lock_d    = lock_tog;
    if (!poll_i.sleep_blocked && !hold_deep && !deep_hit && light_hit) begin
      lock_d = 1'b1;
    end
    sensor_off = (toggled & lock_tog) | (lock_d & ~lock_tog) | deep;

    // Idle saving on the reader screen.
    saving_d = saving_act;
    delay    = DELAY_1MS;
    if (!deep && poll_i.on_reader) begin
      if (idle >= cfg_i.saving_idle_ms) begin
        saving_d = 1'b1;
        delay    = DELAY_50MS;
      end else begin
        delay    = DELAY_10MS;
      end
    end

    res_o.enter_deep_sleep = deep;
    res_o.tilt_locked      = lock_d;
    res_o.tilt_toggled     = toggled;
    res_o.tilt_sensor_off  = sensor_off;
    res_o.wake_released    = pend_wake & ~poll_i.power_pressed;
    res_o.wake_pending     = pending_d;
    res_o.power_saving     = saving_d;
    res_o.idle_delay       = delay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_act_q <= '0;
      allow_q    <= '0;
      pending_q  <= 1'b0;
      rel_wake_q <= 1'b0;
      lock_q     <= 1'b0;
      saving_q   <= 1'b0;
    end else if (step_i) begin
      last_act_q <= last_act_d;
      allow_q    <= allow_d;
      pending_q  <= pending_d;
      rel_wake_q <= rel_wake_d;
      lock_q     <= lock_d;
      saving_q   <= saving_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sleep_and_tilt_lock_controller_top.sv @@
// ----------------------------------------------------------------------------
// sleep_and_tilt_lock_controller_top
// Sleep and tilt-lock controller: one result per poll.
//
//   Channel   Direction  Handshake     Carries
//   in_i      sink       valid/ready   one poll (timestamp, button and screen flags)
//   out_o     source     valid/ready   one result (sleep, lock, saving, delay class)
//   cfg_*     input      write enable  five configuration registers, no read-back
//
// A poll is captured in the input register, evaluated against the state and
// written to the result register once that register is free or being read, so
// one poll is taken every cycle while the result side does not stall. The state
// update for a poll happens in the same cycle as its result is registered,
// which is what sets the one-poll-a-cycle rate. A stalled result holds both
// registers; the input side keeps taking polls while the input register is
// empty or advancing. Reset clears the state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sleep_and_tilt_lock_controller_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  slt_poll_if.sink                          in_i,
  slt_res_if.source                         out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [slt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [slt_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import slt_pkg::*;

  cfg_t  cfg;
  poll_t poll_q;
  res_t  res_d, res_q;
  logic  in_valid_q, out_valid_q;
  logic  step, in_take;

  slt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  slt_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .poll_i(poll_q),
    .cfg_i (cfg),
    .res_o (res_d)
  );

  assign step    = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_take = in_i.valid & in_i.ready;
  assign in_i.ready = ~in_valid_q | step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      poll_q.wake_hold      <= in_i.wake_hold;
      poll_q.now_ms         <= in_i.now_ms;
      poll_q.power_pressed  <= in_i.power_pressed;
      poll_q.any_pressed    <= in_i.any_pressed;
      poll_q.any_released   <= in_i.any_released;
      poll_q.power_released <= in_i.power_released;
      poll_q.power_held_ms  <= in_i.power_held_ms;
      poll_q.tilt_activity  <= in_i.tilt_activity;
      poll_q.sleep_blocked  <= in_i.sleep_blocked;
      poll_q.on_reader      <= in_i.on_reader;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.enter_deep_sleep = res_q.enter_deep_sleep;
  assign out_o.tilt_locked      = res_q.tilt_locked;
  assign out_o.tilt_toggled     = res_q.tilt_toggled;
  assign out_o.tilt_sensor_off  = res_q.tilt_sensor_off;
  assign out_o.wake_released    = res_q.wake_released;
  assign out_o.wake_pending     = res_q.wake_pending;
  assign out_o.power_saving     = res_q.power_saving;
  assign out_o.idle_delay       = res_q.idle_delay;

endmodule

`default_nettype wire

@@ rtl/core/slt_checker.sv @@
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks on the result channel of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       deep_i,
  input wire logic       locked_i,
  input wire logic       toggled_i,
  input wire logic       sensor_off_i,
  input wire logic       wake_released_i,
  input wire logic       wake_pending_i,
  input wire logic       saving_i,
  input wire logic [1:0] delay_i
);
  import slt_pkg::*;

  // A waiting result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transfer");

  // Deep sleep always puts the tilt sensor to sleep and skips idle saving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && deep_i |-> sensor_off_i && (delay_i == DELAY_1MS))
    else $error("deep sleep without sensor off or with a delay class");

  // A released wake hold cannot still be pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && wake_released_i |-> !wake_pending_i)
    else $error("wake hold released and pending together");

  // The slowest loop delay only comes with power saving engaged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (delay_i == DELAY_50MS) |-> saving_i)
    else $error("long delay class without power saving");

  // A toggle that locks must also put the sensor to sleep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && toggled_i && locked_i |-> sensor_off_i)
    else $error("tilt lock engaged by toggle without sensor off");

endmodule

bind sleep_and_tilt_lock_controller_top slt_checker u_slt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .deep_i         (out_o.enter_deep_sleep),
  .locked_i       (out_o.tilt_locked),
  .toggled_i      (out_o.tilt_toggled),
  .sensor_off_i   (out_o.tilt_sensor_off),
  .wake_released_i(out_o.wake_released),
  .wake_pending_i (out_o.wake_pending),
  .saving_i       (out_o.power_saving),
  .delay_i        (out_o.idle_delay)
);

`default_nettype wire

@@ tb/sleep_and_tilt_lock_controller_top_test.sv @@
// ----------------------------------------------------------------------------
// sleep_and_tilt_lock_controller_top_test
// Self-checking bench for the sleep and tilt-lock controller. Polls are queued
// by a stimulus process, short directed sequences and then button-press
// runs mixed with random polls, and are sent by a clocked driver. Every
// accepted poll updates a shadow of the controller state, and the result it
// predicts is compared field by field with what the block returns. Both
// channels stall at random, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module sleep_and_tilt_lock_controller_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int unsigned    ClkPeriod  = 10;
  localparam longint unsigned RunLimitNs = 5_000_000;
  localparam int unsigned    MaxGap     = 15;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  slt_poll_if poll_ch ();
  slt_res_if  res_ch ();

  sleep_and_tilt_lock_controller_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (poll_ch),
    .out_o       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Register values as the block should hold them, and its expected state.
  cfg_t        cfg_live;
  logic [31:0] ctl_last_activity;
  logic [31:0] ctl_allow_sleep;
  logic        ctl_wake_pending;
  logic        ctl_released;
  logic        ctl_lock;
  logic        ctl_saving;

  poll_t       pending_polls[$];
  res_t        expected_results[$];
  poll_t       cur_poll = '0;
  bit          poll_active = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned idle_odds = 0;
  logic [31:0] clock_now;

  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned phases_run = 0;
  int unsigned deep_seen = 0;
  int unsigned toggles_seen = 0;
  int unsigned saving_seen = 0;
  int unsigned releases_seen = 0;

  assign poll_ch.wake_hold      = cur_poll.wake_hold;
  assign poll_ch.now_ms         = cur_poll.now_ms;
  assign poll_ch.power_pressed  = cur_poll.power_pressed;
  assign poll_ch.any_pressed    = cur_poll.any_pressed;
  assign poll_ch.any_released   = cur_poll.any_released;
  assign poll_ch.power_released = cur_poll.power_released;
  assign poll_ch.power_held_ms  = cur_poll.power_held_ms;
  assign poll_ch.tilt_activity  = cur_poll.tilt_activity;
  assign poll_ch.sleep_blocked  = cur_poll.sleep_blocked;
  assign poll_ch.on_reader      = cur_poll.on_reader;

  // Applies one poll to the shadow state in the order the block handles it:
  // wake hold, activity, wake release, lock toggle, sleep check, idle saving.
  function automatic res_t predict_poll(input poll_t p);
    res_t        r;
    logic [31:0] idle_ms;
    r = '0;
    if (p.wake_hold) begin
      ctl_wake_pending  = 1'b1;
      ctl_allow_sleep   = p.now_ms + {16'd0, cfg_live.wake_guard_ms};
      ctl_last_activity = p.now_ms;
    end
    if (p.any_pressed || p.any_released || p.tilt_activity) begin
      ctl_last_activity = p.now_ms;
      ctl_saving        = 1'b0;
    end
    if (!p.power_pressed) ctl_released = 1'b1;
    if (ctl_wake_pending && !p.power_pressed) begin
      ctl_wake_pending = 1'b0;
      r.wake_released  = 1'b1;
    end
    if (!ctl_wake_pending) begin
      if (p.power_released && p.power_held_ms <= cfg_live.short_press_ms) begin
        ctl_lock       = !ctl_lock;
        r.tilt_toggled = 1'b1;
        if (ctl_lock) r.tilt_sensor_off = 1'b1;
      end else if (ctl_lock && (p.any_pressed || p.any_released)) begin
        ctl_lock = 1'b0;
      end
    end
    if (!p.sleep_blocked) begin
      if (ctl_last_activity == 32'd0) ctl_last_activity = p.now_ms;
      // The guard deadline is compared without any allowance for wrap.
      if (ctl_released && p.now_ms >= ctl_allow_sleep && p.power_pressed &&
          p.power_held_ms > cfg_live.short_press_ms) begin
        r.enter_deep_sleep = 1'b1;
      end else begin
        idle_ms = p.now_ms - ctl_last_activity;
        if (cfg_live.deep_timeout_ms != 0 && idle_ms >= cfg_live.deep_timeout_ms) begin
          r.enter_deep_sleep = 1'b1;
        end else if (cfg_live.light_timeout_ms != 0 && !ctl_lock &&
                     idle_ms >= cfg_live.light_timeout_ms) begin
          ctl_lock          = 1'b1;
          r.tilt_sensor_off = 1'b1;
        end
      end
      if (r.enter_deep_sleep) r.tilt_sensor_off = 1'b1;
    end
    r.idle_delay = DELAY_1MS;
    if (!r.enter_deep_sleep && p.on_reader) begin
      idle_ms = p.now_ms - ctl_last_activity;
      if (idle_ms >= cfg_live.saving_idle_ms) begin
        ctl_saving   = 1'b1;
        r.idle_delay = DELAY_50MS;
      end else begin
        r.idle_delay = DELAY_10MS;
      end
    end
    r.tilt_locked  = ctl_lock;
    r.wake_pending = ctl_wake_pending;
    r.power_saving = ctl_saving;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [1:0] want,
                             input logic [1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: a new poll is put on the channel at the falling edge once the
  // previous one has been transferred, unless a sender gap is running.
  always @(negedge clk_i) begin
    if (!poll_active) begin
      if (send_gap != 0) begin
        send_gap--;
        poll_ch.valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        send_gap = $urandom_range(1, MaxGap) - 1;
        poll_ch.valid <= 1'b0;
      end else if (pending_polls.size() != 0) begin
        cur_poll    = pending_polls.pop_front();
        poll_active = 1'b1;
        poll_ch.valid <= 1'b1;
      end else begin
        poll_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (recv_gap != 0) begin
      recv_gap--;
      res_ch.ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      recv_gap = $urandom_range(1, MaxGap) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Monitor: predicts on every poll transfer and checks every result transfer.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && poll_ch.valid && poll_ch.ready) begin
      expected_results.push_back(predict_poll(cur_poll));
      poll_active = 1'b0;
    end
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result transfer with no poll outstanding", $time);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("enter_deep_sleep", want.enter_deep_sleep, res_ch.enter_deep_sleep);
        check_field("tilt_locked", want.tilt_locked, res_ch.tilt_locked);
        check_field("tilt_toggled", want.tilt_toggled, res_ch.tilt_toggled);
        check_field("tilt_sensor_off", want.tilt_sensor_off, res_ch.tilt_sensor_off);
        check_field("wake_released", want.wake_released, res_ch.wake_released);
        check_field("wake_pending", want.wake_pending, res_ch.wake_pending);
        check_field("power_saving", want.power_saving, res_ch.power_saving);
        check_field("idle_delay", want.idle_delay, res_ch.idle_delay);
        results_checked++;
        deep_seen     += want.enter_deep_sleep;
        toggles_seen  += want.tilt_toggled;
        saving_seen   += want.power_saving;
        releases_seen += want.wake_released;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_DEEP_TIMEOUT:  cfg_live.deep_timeout_ms  = value;
      REG_LIGHT_TIMEOUT: cfg_live.light_timeout_ms = value;
      REG_SAVING_IDLE:   cfg_live.saving_idle_ms   = value;
      REG_SHORT_PRESS:   cfg_live.short_press_ms   = value[15:0];
      REG_WAKE_GUARD:    cfg_live.wake_guard_ms    = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic [31:0] deep_ms, input logic [31:0] light_ms,
                                input logic [31:0] saving_ms, input logic [15:0] short_ms,
                                input logic [15:0] guard_ms);
    write_reg(REG_DEEP_TIMEOUT, deep_ms);
    write_reg(REG_LIGHT_TIMEOUT, light_ms);
    write_reg(REG_SAVING_IDLE, saving_ms);
    write_reg(REG_SHORT_PRESS, {16'd0, short_ms});
    write_reg(REG_WAKE_GUARD, {16'd0, guard_ms});
    phases_run++;
  endtask

  task automatic wait_until_drained();
    while (pending_polls.size() != 0 || poll_active || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void queue_poll(input logic wake, input logic [31:0] now_ms,
                                     input logic pwr, input logic pressed,
                                     input logic released, input logic pwr_rel,
                                     input logic [15:0] held, input logic tilt,
                                     input logic blocked, input logic reader);
    poll_t p;
    p.wake_hold      = wake;
    p.now_ms         = now_ms;
    p.power_pressed  = pwr;
    p.any_pressed    = pressed;
    p.any_released   = released;
    p.power_released = pwr_rel;
    p.power_held_ms  = held;
    p.tilt_activity  = tilt;
    p.sleep_blocked  = blocked;
    p.on_reader      = reader;
    pending_polls.push_back(p);
    clock_now = now_ms;
  endfunction

  // Hold durations cluster around the short-press bound.
  function automatic logic [15:0] random_hold();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, cfg_live.short_press_ms));
      1:       return cfg_live.short_press_ms;
      2:       return cfg_live.short_press_ms + 16'd1;
      3:       return 16'($urandom_range(0, 16'hFFFF));
      4:       return 16'hFFFF;
      default: return 16'($urandom_range(cfg_live.short_press_ms, 16'hFFFF));
    endcase
  endfunction

  // Time steps are mostly small, else mostly scaled to one of the timeouts so that they expire.
  function automatic logic [31:0] step_ms();
    logic [31:0] span;
    int unsigned pick;
    case ($urandom_range(0, 3))
      0:       span = cfg_live.deep_timeout_ms;
      1:       span = cfg_live.light_timeout_ms;
      2:       span = cfg_live.saving_idle_ms;
      default: span = {16'd0, cfg_live.wake_guard_ms};
    endcase
    if (span == 0 || span > 200000) span = 3000;
    pick = $urandom_range(0, 99);
    if (pick < 55) return $urandom_range(0, 40);
    if (pick < 93) return $urandom_range(span / 2, span + span / 4);
    if (pick < 98) return $urandom();
    return 32'd0;
  endfunction

  function automatic void queue_noise_poll();
    poll_t p;
    clock_now += step_ms();
    p.wake_hold      = ($urandom_range(0, 19) == 0);
    p.now_ms         = clock_now;
    p.power_pressed  = ($urandom_range(0, 2) == 0);
    p.any_pressed    = ($urandom_range(0, 7) == 0);
    p.any_released   = ($urandom_range(0, 7) == 0);
    p.power_released = ($urandom_range(0, 5) == 0);
    p.power_held_ms  = random_hold();
    p.tilt_activity  = ($urandom_range(0, 7) == 0);
    p.sleep_blocked  = ($urandom_range(0, 5) == 0);
    p.on_reader      = 1'($urandom_range(0, 1));
    pending_polls.push_back(p);
  endfunction

  // A full press of the power button: press (or wake with it held), a few
  // polls while held, then the release, with time following the hold count.
  function automatic int unsigned queue_press_run();
    poll_t       p;
    int unsigned holds;
    logic [15:0] target;
    logic [15:0] held_prev;
    logic        reader;
    holds     = $urandom_range(0, 5);
    target    = random_hold();
    reader    = 1'($urandom_range(0, 1));
    held_prev = 16'd0;
    clock_now += step_ms();
    p = '0;
    p.wake_hold     = ($urandom_range(0, 3) == 0);
    p.any_pressed   = !p.wake_hold;
    p.power_pressed = 1'b1;
    p.now_ms        = clock_now;
    p.on_reader     = reader;
    p.sleep_blocked = ($urandom_range(0, 7) == 0);
    pending_polls.push_back(p);
    for (int unsigned k = 1; k <= holds + 1; k++) begin
      p = '0;
      p.power_held_ms = 16'((32'(target) * k) / (holds + 1));
      clock_now += 32'(p.power_held_ms - held_prev);
      held_prev       = p.power_held_ms;
      p.now_ms        = clock_now;
      p.on_reader     = reader;
      p.sleep_blocked = ($urandom_range(0, 7) == 0);
      p.tilt_activity = ($urandom_range(0, 7) == 0);
      if (k == holds + 1) begin
        p.power_released = 1'b1;
        p.any_released   = 1'b1;
      end else begin
        p.power_pressed = 1'b1;
      end
      pending_polls.push_back(p);
    end
    return holds + 2;
  endfunction

  task automatic queue_random_polls(input int unsigned count);
    int unsigned made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 6) begin
        made += queue_press_run();
      end else begin
        queue_noise_poll();
        made++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    poll_ch.valid = 1'b0;
    res_ch.ready  = 1'b0;
    cfg_live.deep_timeout_ms  = DEEP_TIMEOUT_RST;
    cfg_live.light_timeout_ms = LIGHT_TIMEOUT_RST;
    cfg_live.saving_idle_ms   = SAVING_IDLE_RST;
    cfg_live.short_press_ms   = SHORT_PRESS_RST;
    cfg_live.wake_guard_ms    = WAKE_GUARD_RST;
    ctl_last_activity = '0;
    ctl_allow_sleep   = '0;
    ctl_wake_pending  = 1'b0;
    ctl_released      = 1'b0;
    ctl_lock          = 1'b0;
    ctl_saving        = 1'b0;
    clock_now         = '0;
    idle_odds         = 8;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    phases_run++;

    // Register defaults. The first polls leave the activity time at zero, so
    // the sleep check has to pick up the current time on its own.
    queue_poll(1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1);
    queue_poll(1'b0, 32'd500, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b1, 1'b1);
    queue_poll(1'b0, 32'd1500, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1);
    // Wake with the button held, then a long hold inside the guard time.
    queue_poll(1'b1, 32'd2000, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
    queue_poll(1'b0, 32'd2100, 1'b1, 1'b0, 1'b0, 1'b0, 16'd900, 1'b0, 1'b0, 1'b0);
    // Release consumes the wake, and the same short press locks the tilt.
    queue_poll(1'b0, 32'd2200, 1'b0, 1'b0, 1'b1, 1'b1, 16'd300, 1'b0, 1'b0, 1'b0);
    queue_poll(1'b0, 32'd2300, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
    queue_poll(1'b0, 32'd2400, 1'b0, 1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    queue_poll(1'b0, 32'd2500, 1'b0, 1'b0, 1'b1, 1'b1, 16'd800, 1'b0, 1'b0, 1'b0);
    queue_poll(1'b0, 32'd2600, 1'b0, 1'b0, 1'b1, 1'b1, 16'd801, 1'b0, 1'b0, 1'b0);
    queue_poll(1'b0, 32'd5000, 1'b1, 1'b0, 1'b0, 1'b0, 16'd801, 1'b0, 1'b0, 1'b1);
    // A wake near the top of the count: the guard deadline wraps past zero.
    queue_poll(1'b1, 32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    queue_poll(1'b0, 32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1);
    queue_poll(1'b0, 32'h0000_0500, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1);
    queue_poll(1'b0, 32'h0000_0600, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1, 1'b0, 1'b1);
    queue_poll(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    queue_poll(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
    queue_random_polls(250);
    wait_until_drained();

    // Timeouts on, and writes to the unused indexes must change nothing.
    idle_odds = 20;
    apply_settings(32'd5000, 32'd3000, 32'd1000, 16'd800, 16'd2000);
    for (int k = int'(REG_WAKE_GUARD) + 1; k < (1 << CfgIdxW); k++)
      write_reg(k[CfgIdxW-1:0], 32'hFFFF_FFFF);
    queue_poll(1'b0, clock_now + 32'd10, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b1, 1'b0, 1'b1);
    queue_poll(1'b0, clock_now + 32'd1000, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1);
    queue_poll(1'b0, clock_now + 32'd3000, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1);
    queue_poll(1'b0, clock_now + 32'd3000, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1);
    queue_poll(1'b0, clock_now + 32'd1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b1, 1'b1);
    queue_random_polls(300);
    wait_until_drained();

    idle_odds = 0;
    apply_settings(32'd0, 32'd0, 32'd0, 16'd0, 16'd0);
    queue_random_polls(250);
    wait_until_drained();

    idle_odds = 12;
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    queue_random_polls(250);
    wait_until_drained();

    idle_odds = 6;
    apply_settings(32'd1, 32'd1, 32'd1, 16'd1, 16'd1);
    queue_random_polls(250);
    wait_until_drained();

    idle_odds = 30;
    apply_settings($urandom_range(2000, 60000), $urandom_range(500, 30000),
                   $urandom_range(0, 5000), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(0, 10000)));
    queue_random_polls(300);
    wait_until_drained();

    // Final stretch runs at full rate on both sides.
    idle_odds = 0;
    apply_settings($urandom(), $urandom(), $urandom(), 16'($urandom_range(0, 16'hFFFF)),
                   16'($urandom_range(0, 16'hFFFF)));
    queue_random_polls(300);
    wait_until_drained();

    $display("Checked %0d results across %0d register settings, with random stalls.",
             results_checked, phases_run);
    $display("Seen %0d deep-sleep requests, %0d lock toggles, %0d wake releases, %0d saving.",
             deep_seen, toggles_seen, releases_seen, saving_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("%0t: run did not finish in time", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
